// ===== hw/rtl/apdc_pkg.sv =====
// Shared types, constants and round function of the Alzette pair difference counter.
package apdc_pkg;

  localparam int CountWidth  = 32;
  localparam int NumCounters = 64;
  localparam int WordWidth   = 32;
  localparam int IdxWidth    = $clog2(NumCounters);
  localparam int NumRounds   = 4;

  localparam logic [WordWidth-1:0] LeftDiffReset  = 32'h0000_0000;
  localparam logic [WordWidth-1:0] RightDiffReset = 32'h0000_0001;
  localparam logic [WordWidth-1:0] RoundConstReset = 32'hB7E1_5162;

  localparam int RotA [NumRounds] = '{31, 17, 0, 24};
  localparam int RotB [NumRounds] = '{24, 17, 31, 16};

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_LEFT_DIFF   = 2'd0,
    REG_RIGHT_DIFF  = 2'd1,
    REG_ROUND_CONST = 2'd2
  } reg_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [IdxWidth-1:0]  idx;
    logic [WordWidth-1:0] xa;
    logic [WordWidth-1:0] ya;
    logic [WordWidth-1:0] xb;
    logic [WordWidth-1:0] yb;
  } pipe_t;

  function automatic logic [WordWidth-1:0] rotr(input logic [WordWidth-1:0] v, input int s);
    logic [2*WordWidth-1:0] t;
    t = {v, v} >> s;
    return t[WordWidth-1:0];
  endfunction

  function automatic logic [2*WordWidth-1:0] alz_round(input logic [WordWidth-1:0] x,
                                                       input logic [WordWidth-1:0] y,
                                                       input logic [WordWidth-1:0] k,
                                                       input int ra,
                                                       input int rb);
    logic [WordWidth-1:0] xn;
    logic [WordWidth-1:0] yn;
    xn = x + rotr(y, ra);
    yn = y ^ rotr(xn, rb);
    xn = xn ^ k;
    return {yn, xn};
  endfunction

  function automatic pipe_t round_pair(input pipe_t p, input int r,
                                       input logic [WordWidth-1:0] k);
    pipe_t                  q;
    logic [2*WordWidth-1:0] a;
    logic [2*WordWidth-1:0] b;
    q    = p;
    a    = alz_round(p.xa, p.ya, k, RotA[r], RotB[r]);
    b    = alz_round(p.xb, p.yb, k, RotA[r], RotB[r]);
    q.xa = a[WordWidth-1:0];
    q.ya = a[2*WordWidth-1:WordWidth];
    q.xb = b[WordWidth-1:0];
    q.yb = b[2*WordWidth-1:WordWidth];
    return q;
  endfunction

endpackage

// ===== hw/rtl/apdc_counters.sv =====
// Bank of saturating hit counters with bulk clear and one read port.
module apdc_counters
  import apdc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   inc_en_i,
  input  logic [NumCounters-1:0] hit_i,
  input  logic                   clr_i,
  input  logic [IdxWidth-1:0]    rd_idx_i,
  output logic [WordWidth-1:0]   rd_value_o
);

  localparam logic [CountWidth-1:0] CntMax = '1;

  logic [CountWidth-1:0] cnt_q [NumCounters];
  logic [63:0]           rd_wide;

  for (genvar i = 0; i < NumCounters; i++) begin : g_cnt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[i] <= '0;
      end else if (clr_i) begin
        cnt_q[i] <= '0;
      end else if (inc_en_i && hit_i[i] && (cnt_q[i] != CntMax)) begin
        cnt_q[i] <= cnt_q[i] + 1'b1;
      end
    end
  end

  assign rd_wide    = 64'(cnt_q[rd_idx_i]);
  assign rd_value_o = rd_wide[WordWidth-1:0];

  a_clr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_i |=> (rd_value_o == '0))
    else $error("counter nonzero after clear");

  a_inc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inc_en_i && hit_i[0] && !clr_i && (cnt_q[0] != CntMax)) |=>
      (cnt_q[0] == $past(cnt_q[0]) + 1'b1))
    else $error("counter missed increment");

  a_sat_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!clr_i && (cnt_q[0] == CntMax)) |=> (cnt_q[0] == CntMax))
    else $error("saturated counter wrapped");

endmodule

// ===== hw/rtl/alzette_pair_difference_counter.sv =====
// Alzette pair difference counter: item pipeline, configuration and result register.
// Takes one beat per cycle unless the output stalls, and returns one beat per input beat, in
// order. A beat passes an input register, four round stages (one Alzette round on both pairs
// per stage, one 32-bit add deep) and the result register. The 64 saturating counters are
// updated, cleared or read as a beat leaves the last round stage, so reads always see every
// earlier sample. Configuration writes take effect at once and belong only in idle periods.
module alzette_pair_difference_counter
  import apdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // left_word, right_word, counter_index, zero pad
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // delta_left, delta_right, count_value
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int NumStages = NumRounds + 1;

  logic [WordWidth-1:0] left_diff_q;
  logic [WordWidth-1:0] right_diff_q;
  logic [WordWidth-1:0] round_const_q;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] up_valid;
  logic [NumStages:0]   ready;
  pipe_t                stage_q [NumStages];
  pipe_t                stage_d [NumStages];
  pipe_t                in_item;
  pipe_t                last;

  logic                 out_valid_q;
  logic [WordWidth-1:0] dl_q;
  logic [WordWidth-1:0] dr_q;
  logic [WordWidth-1:0] cv_q;
  logic [WordWidth-1:0] dl;
  logic [WordWidth-1:0] dr;
  logic [WordWidth-1:0] rd_value;
  logic                 fire;
  logic                 inc_en;
  logic                 clr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_diff_q   <= LeftDiffReset;
      right_diff_q  <= RightDiffReset;
      round_const_q <= RoundConstReset;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_LEFT_DIFF:   left_diff_q   <= cfg_data_i;
        REG_RIGHT_DIFF:  right_diff_q  <= cfg_data_i;
        REG_ROUND_CONST: round_const_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.cmd = cmd_e'(s_axis_tuser);
    in_item.xa  = s_axis_tdata[31:0];
    in_item.ya  = s_axis_tdata[63:32];
    in_item.idx = s_axis_tdata[69:64];
    in_item.xb  = s_axis_tdata[31:0] ^ left_diff_q;
    in_item.yb  = s_axis_tdata[63:32] ^ right_diff_q;
  end

  assign ready[NumStages] = !out_valid_q || m_axis_tready;

  for (genvar i = 0; i < NumStages; i++) begin : g_stage
    assign ready[i] = !valid_q[i] || ready[i+1];

    if (i == 0) begin : g_in
      assign up_valid[i] = s_axis_tvalid;
      assign stage_d[i]  = in_item;
    end else begin : g_rnd
      assign up_valid[i] = valid_q[i-1];
      assign stage_d[i]  = round_pair(stage_q[i-1], i - 1, round_const_q);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (ready[i]) begin
        valid_q[i] <= up_valid[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[i] && up_valid[i]) begin
        stage_q[i] <= stage_d[i];
      end
    end
  end

  assign s_axis_tready = ready[0];

  assign last   = stage_q[NumStages-1];
  assign fire   = valid_q[NumStages-1] && ready[NumStages];
  assign dl     = last.xa ^ last.xb;
  assign dr     = last.ya ^ last.yb;
  assign inc_en = fire && (last.cmd == CMD_SAMPLE);
  assign clr    = fire && (last.cmd == CMD_CLEAR);

  apdc_counters u_counters (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .inc_en_i   (inc_en),
    .hit_i      ({dr, dl}),
    .clr_i      (clr),
    .rd_idx_i   (last.idx),
    .rd_value_o (rd_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready[NumStages]) begin
      out_valid_q <= valid_q[NumStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      dl_q <= (last.cmd == CMD_SAMPLE) ? dl : '0;
      dr_q <= (last.cmd == CMD_SAMPLE) ? dr : '0;
      cv_q <= (last.cmd == CMD_READ) ? rd_value : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {cv_q, dr_q, dl_q};

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(valid_q[NumStages-1]))
    else $error("result without a beat in the last stage");

  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> valid_q[0])
    else $error("accepted beat lost at input register");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&valid_q) && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input ready while pipeline full and stalled");

endmodule

// ===== tb/tb_alzette_pair_difference_counter.sv =====
// Self-checking stream testbench for the Alzette pair difference counter with its own predictor.
`timescale 1ns / 100ps

module tb_alzette_pair_difference_counter;
  import apdc_pkg::*;

  localparam int          ClkPeriod  = 10;
  localparam int          CycleLimit = 300000;
  localparam int          LongHold   = 400;
  localparam int          Settle     = 10;
  localparam logic [1:0]  CmdUnused  = 2'd3;

  typedef struct packed {
    logic [31:0] delta_left;
    logic [31:0] delta_right;
    logic [31:0] count_value;
  } result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;  // left_word, right_word, counter_index, zero pad
  logic [1:0]  s_axis_tuser  = '0;  // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;        // delta_left, delta_right, count_value
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = '0;
  logic [31:0] cfg_data_i    = '0;

  logic [31:0] hit_count [NumCounters];
  logic [31:0] left_diff;
  logic [31:0] right_diff;
  logic [31:0] round_key;
  result_t     pending_results [$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned results_checked;
  int unsigned num_samples;
  int unsigned num_reads;
  int unsigned num_clears;
  int unsigned num_unused;
  int unsigned burst_left;

  int unsigned hold_req;
  int unsigned hold_ack;
  int unsigned hold_left;
  int unsigned stall_mode;
  int unsigned stall_mode_left;

  alzette_pair_difference_counter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
    if (s == 0) begin
      return v;
    end
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [63:0] alzette_box(input logic [31:0] x_in, input logic [31:0] y_in,
                                              input logic [31:0] k);
    logic [31:0] x;
    logic [31:0] y;
    x = x_in;
    y = y_in;
    x = x + ror32(y, 31); y = y ^ ror32(x, 24); x = x ^ k;
    x = x + ror32(y, 17); y = y ^ ror32(x, 17); x = x ^ k;
    x = x + y;            y = y ^ ror32(x, 31); x = x ^ k;
    x = x + ror32(y, 24); y = y ^ ror32(x, 16); x = x ^ k;
    return {y, x};
  endfunction

  function automatic void bump_counter(input int unsigned idx);
    if (hit_count[idx] != '1) begin
      hit_count[idx] = hit_count[idx] + 1;
    end
  endfunction

  function automatic result_t tally_item(input logic [1:0] cmd, input logic [31:0] lw,
                                         input logic [31:0] rw, input logic [5:0] idx);
    result_t     res;
    logic [63:0] base_out;
    logic [63:0] twin_out;
    res = '0;
    case (cmd)
      CMD_SAMPLE: begin
        base_out        = alzette_box(lw, rw, round_key);
        twin_out        = alzette_box(lw ^ left_diff, rw ^ right_diff, round_key);
        res.delta_left  = base_out[31:0] ^ twin_out[31:0];
        res.delta_right = base_out[63:32] ^ twin_out[63:32];
        for (int i = 0; i < 32; i++) begin
          if (res.delta_left[i]) bump_counter(i);
          if (res.delta_right[i]) bump_counter(i + 32);
        end
        num_samples++;
      end
      CMD_READ: begin
        res.count_value = hit_count[idx];
        num_reads++;
      end
      CMD_CLEAR: begin
        foreach (hit_count[i]) hit_count[i] = '0;
        num_clears++;
      end
      default: begin
        num_unused++;
      end
    endcase
    return res;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [31:0] lw, input logic [31:0] rw,
                           input logic [5:0] idx);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, idx, rw, lw};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(tally_item(cmd, lw, rw, idx));
    burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] ldiff, input logic [31:0] rdiff,
                            input logic [31:0] key);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_LEFT_DIFF;
    cfg_data_i  <= ldiff;
    @(posedge clk_i);
    cfg_index_i <= REG_RIGHT_DIFF;
    cfg_data_i  <= rdiff;
    @(posedge clk_i);
    cfg_index_i <= REG_ROUND_CONST;
    cfg_data_i  <= key;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    left_diff  = ldiff;
    right_diff = rdiff;
    round_key  = key;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random_item();
    logic [1:0]  cmd;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)      cmd = CMD_SAMPLE;
    else if (pick < 90) cmd = CMD_READ;
    else if (pick < 93) cmd = CMD_CLEAR;
    else                cmd = CmdUnused;
    send_item(cmd, pick_word(), pick_word(), 6'($urandom_range(0, 63)));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack      <= hold_req;
      hold_left     <= LongHold;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode      <= $urandom_range(0, 2);
        stall_mode_left <= $urandom_range(10, 80);
      end else begin
        stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64]};
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result beat: expected none, actual %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.delta_left !== want.delta_left) begin
          $display("%0t delta_left mismatch: expected %h, actual %h",
                   $time, want.delta_left, got.delta_left);
          error_count++;
        end
        if (got.delta_right !== want.delta_right) begin
          $display("%0t delta_right mismatch: expected %h, actual %h",
                   $time, want.delta_right, got.delta_right);
          error_count++;
        end
        if (got.count_value !== want.count_value) begin
          $display("%0t count_value mismatch: expected %h, actual %h",
                   $time, want.count_value, got.count_value);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(CMD_SAMPLE, 32'h0000_0000, 32'h0000_0000, 6'd0);
    send_item(CMD_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_item(CMD_SAMPLE, 32'h5555_5555, 32'hAAAA_AAAA, 6'd21);
    send_item(CMD_SAMPLE, 32'hAAAA_AAAA, 32'h5555_5555, 6'd42);
    send_item(CMD_READ, 32'h0000_0000, 32'h0000_0000, 6'd0);
    send_item(CMD_READ, 32'h0000_0000, 32'h0000_0000, 6'd31);
    send_item(CMD_READ, 32'h0000_0000, 32'h0000_0000, 6'd32);
    send_item(CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_item(CmdUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_item(CmdUnused, 32'h0000_0000, 32'h0000_0000, 6'd0);
    send_item(CMD_READ, 32'h0000_0000, 32'h0000_0000, 6'd5);
    send_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_item(CMD_READ, 32'h0000_0000, 32'h0000_0000, 6'd0);
    send_item(CMD_READ, 32'h0000_0000, 32'h0000_0000, 6'd63);
    for (int i = 0; i < 4; i++) begin
      send_item(CMD_SAMPLE, $urandom(), $urandom(), 6'($urandom_range(0, 63)));
    end
    send_item(CMD_READ, 32'h0000_0000, 32'h0000_0000, 6'd40);
    send_item(CMD_READ, 32'h0000_0000, 32'h0000_0000, 6'd10);
    send_item(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000, 6'd0);
  endtask

  task automatic test_config_phases();
    logic [31:0] settings [6][3];
    settings = '{
      '{$urandom(), $urandom(), $urandom()},
      '{32'h0000_0000, 32'h0000_0000, $urandom()},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000},
      '{32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF},
      '{32'h0000_0001, 32'h8000_0000, $urandom()},
      '{LeftDiffReset, RightDiffReset, RoundConstReset}
    };
    foreach (settings[p]) begin
      set_config(settings[p][0], settings[p][1], settings[p][2]);
      repeat (165) send_random_item();
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_req <= hold_req + 1;
    repeat (40) send_random_item();
    wait_idle();
  endtask

  initial begin
    foreach (hit_count[i]) hit_count[i] = '0;
    left_diff  = LeftDiffReset;
    right_diff = RightDiffReset;
    round_key  = RoundConstReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_config_phases();
    test_backpressure();
    wait_idle();

    $display("Checked %0d results: %0d samples, %0d reads, %0d clears, %0d unused commands",
             results_checked, num_samples, num_reads, num_clears, num_unused);
    $display("Covered six difference and constant settings plus a long output stall");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
